FILE: hdl/u8v_pkg.sv
// Package: shared types and byte constants for the UTF-8 stream validator.
`timescale 1ns / 1ps
`default_nettype none

package u8v_pkg;

    // Allowed range for the next continuation byte
    typedef enum logic [2:0] {
        RANGE_PLAIN = 3'd0,  // 80-BF
        RANGE_A0_BF = 3'd1,
        RANGE_80_9F = 3'd2,
        RANGE_90_BF = 3'd3,
        RANGE_80_8F = 3'd4
    } t_range;

    // Running check state carried from byte to byte
    typedef struct packed {
        logic [1:0] owed;   // continuations still expected
        t_range     rng;    // range for the next continuation
        logic       err;    // sticky error flag
    } t_state;

    localparam t_state STATE_RESET = '{owed: 2'd0, rng: RANGE_PLAIN, err: 1'b0};

    // Byte boundaries
    localparam logic [7:0] BYTE_NUL     = 8'h00;
    localparam logic [7:0] BYTE_ASCII_HI = 8'h7F;
    localparam logic [7:0] LEAD2_LO     = 8'hC2;
    localparam logic [7:0] LEAD2_HI     = 8'hDF;
    localparam logic [7:0] LEAD3_LO     = 8'hE0;
    localparam logic [7:0] LEAD3_HI     = 8'hEF;
    localparam logic [7:0] LEAD3_SURR   = 8'hED;
    localparam logic [7:0] LEAD4_LO     = 8'hF0;
    localparam logic [7:0] LEAD4_HI     = 8'hF4;
    localparam logic [7:0] CONT_LO      = 8'h80;
    localparam logic [7:0] CONT_HI      = 8'hBF;
    localparam logic [7:0] CONT_8F      = 8'h8F;
    localparam logic [7:0] CONT_90      = 8'h90;
    localparam logic [7:0] CONT_9F      = 8'h9F;
    localparam logic [7:0] CONT_A0      = 8'hA0;
    localparam logic [7:0] CONT_MASK    = 8'hC0;

endpackage

`default_nettype wire

FILE: hdl/u8v_if.sv
// Interfaces: byte input channel and verdict output channel.
`timescale 1ns / 1ps
`default_nettype none

interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_verdict_if;
    logic valid;
    logic ready;
    logic text_valid;

    modport source (output valid, output text_valid, input ready);
    modport sink   (input valid, input text_valid, output ready);
endinterface

`default_nettype wire

FILE: hdl/u8v_step.sv
// Per-byte state update and end-of-text verdict for the UTF-8 check.
`timescale 1ns / 1ps
`default_nettype none

module u8v_step (
    input  wire u8v_pkg::t_state i_state,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_last_byte,
    output u8v_pkg::t_state      o_state,
    output logic                 o_text_valid
);

    u8v_pkg::t_state w_upd;

    // True when a continuation byte lies in the allowed range
    function automatic logic in_range(input logic [7:0] b, input u8v_pkg::t_range rng);
        logic ok;
        case (rng)
            u8v_pkg::RANGE_A0_BF: ok = (b >= u8v_pkg::CONT_A0) && (b <= u8v_pkg::CONT_HI);
            u8v_pkg::RANGE_80_9F: ok = (b >= u8v_pkg::CONT_LO) && (b <= u8v_pkg::CONT_9F);
            u8v_pkg::RANGE_90_BF: ok = (b >= u8v_pkg::CONT_90) && (b <= u8v_pkg::CONT_HI);
            u8v_pkg::RANGE_80_8F: ok = (b >= u8v_pkg::CONT_LO) && (b <= u8v_pkg::CONT_8F);
            default:              ok = (b & u8v_pkg::CONT_MASK) == u8v_pkg::CONT_LO;
        endcase
        return ok;
    endfunction

    // Lead or continuation decode; nothing changes once an error is seen
    always_comb begin
        w_upd = i_state;
        if (!i_state.err) begin
            if (i_state.owed == 2'd0) begin
                w_upd.rng = u8v_pkg::RANGE_PLAIN;
                if (i_data_byte == u8v_pkg::BYTE_NUL) begin
                    w_upd.err  = 1'b1;
                    w_upd.owed = 2'd0;
                end else if (i_data_byte <= u8v_pkg::BYTE_ASCII_HI) begin
                    w_upd.owed = 2'd0;
                end else if (i_data_byte >= u8v_pkg::LEAD2_LO &&
                             i_data_byte <= u8v_pkg::LEAD2_HI) begin
                    w_upd.owed = 2'd1;
                end else if (i_data_byte >= u8v_pkg::LEAD3_LO &&
                             i_data_byte <= u8v_pkg::LEAD3_HI) begin
                    w_upd.owed = 2'd2;
                    if (i_data_byte == u8v_pkg::LEAD3_LO) begin
                        w_upd.rng = u8v_pkg::RANGE_A0_BF;
                    end else if (i_data_byte == u8v_pkg::LEAD3_SURR) begin
                        w_upd.rng = u8v_pkg::RANGE_80_9F;
                    end
                end else if (i_data_byte >= u8v_pkg::LEAD4_LO &&
                             i_data_byte <= u8v_pkg::LEAD4_HI) begin
                    w_upd.owed = 2'd3;
                    if (i_data_byte == u8v_pkg::LEAD4_LO) begin
                        w_upd.rng = u8v_pkg::RANGE_90_BF;
                    end else if (i_data_byte == u8v_pkg::LEAD4_HI) begin
                        w_upd.rng = u8v_pkg::RANGE_80_8F;
                    end
                end else begin
                    // stray continuation, C0/C1 or F5-FF
                    w_upd.err  = 1'b1;
                    w_upd.owed = 2'd0;
                end
            end else if (in_range(i_data_byte, i_state.rng)) begin
                w_upd.owed = i_state.owed - 2'd1;
                w_upd.rng  = u8v_pkg::RANGE_PLAIN;
            end else begin
                w_upd.err  = 1'b1;
                w_upd.owed = 2'd0;
                w_upd.rng  = u8v_pkg::RANGE_PLAIN;
            end
        end
    end

    // Verdict on the final byte, then back to the start state
    assign o_text_valid = !w_upd.err && (w_upd.owed == 2'd0);
    assign o_state      = i_last_byte ? u8v_pkg::STATE_RESET : w_upd;

endmodule

`default_nettype wire

FILE: hdl/utf8_stream_validator_core.sv
// Top level: input register, per-byte check, verdict register.
// The verdict is registered: it goes valid once the final byte moves on from the byte register.
// Throughput: one byte per cycle; the byte register and the verdict register
//   let a new byte in while a verdict waits, and only a final byte stalls on it.
// Reset: synchronous, active low; clears the byte and verdict valid flags and
//   returns the check state to no owed continuations and no error.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_validator_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    u8v_byte_if.sink             i_byte,
    u8v_verdict_if.source        o_verdict
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    u8v_pkg::t_state r_state;
    u8v_pkg::t_state n_state;
    logic            r_out_valid;
    logic            r_out_text_valid;
    logic            n_text_valid;
    logic            w_adv;
    logic            w_take;

    // A buffered byte moves on unless it is final and the verdict slot is full
    assign w_adv  = r_in_valid && (!r_in_last || !r_out_valid || o_verdict.ready);
    assign w_take = i_byte.valid && i_byte.ready;

    assign i_byte.ready         = !r_in_valid || w_adv;
    assign o_verdict.valid      = r_out_valid;
    assign o_verdict.text_valid = r_out_text_valid;

    u8v_step u_step (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_state      (n_state),
        .o_text_valid (n_text_valid)
    );

    // Control registers and check state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= u8v_pkg::STATE_RESET;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
            if (w_adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_verdict.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
        if (w_adv && r_in_last) begin
            r_out_text_valid <= n_text_valid;
        end
    end

`ifndef SYNTH
    // A final byte always leaves the start state behind it
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_state.owed == 2'd0 && !r_state.err &&
                                  r_state.rng == u8v_pkg::RANGE_PLAIN))
        else $error("check state not cleared after final byte");

    // A final byte that moves on produces a verdict next cycle
    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> r_out_valid)
        else $error("final byte produced no verdict");

    // An error never leaves continuations owed
    a_err_no_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.err |-> (r_state.owed == 2'd0))
        else $error("error flag set with continuations owed");

    // A held byte keeps its value until it moves on
    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_last)))
        else $error("buffered byte lost while stalled");
`endif

endmodule

`default_nettype wire
